/* hw/rtl/pica_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI controller package
// Shared constants, datapath operation codes and the control and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pica_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_KP          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KI          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TIME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_MAX       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_MIN       = 3'd4;

    // Fixed field widths
    localparam int GAIN_W    = 16;  // Q8.8 gains
    localparam int GAIN_FRAC = 8;
    localparam int TIME_W    = 24;  // Q0.24 sample period
    localparam int FRAC_W    = 16;  // integrator and sum fraction bits
    localparam int LIMIT_W   = 32;
    localparam int SUM_W     = 64;
    localparam int DRIVE_W   = 32;
    localparam int OUT_DATA_W = ((DRIVE_W + 1 + 7) / 8) * 8;

    // Register reset values
    localparam logic [GAIN_W-1:0]         KP_RESET    = 16'd256;
    localparam logic [GAIN_W-1:0]         KI_RESET    = 16'd256;
    localparam logic [TIME_W-1:0]         ST_RESET    = 24'd1678;
    localparam logic signed [LIMIT_W-1:0] Y_MAX_RESET = 32'sd32767;
    localparam logic signed [LIMIT_W-1:0] Y_MIN_RESET = -32'sd32768;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_PRE,
        OP_MUL_P,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_INC,
        OP_INTEG,
        OP_SUM,
        OP_OUT,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear;
    } dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/pica_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI controller sequencer
// Steps the datapath through one sample: gain products, the split increment
// product, integration, sum and the output write, or a reset command's write.
// ----------------------------------------------------------------------------
module pica_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pica_pkg::dp_status_t dp_status,
    output pica_pkg::dp_cmd_t    dp_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PRE,
        ST_MUL_P,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_INC,
        ST_INTEG,
        ST_SUM,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        dp_cmd.load = s_tvalid && (state_reg == ST_IDLE);
        dp_cmd.op   = pica_pkg::OP_NONE;
        case (state_reg)
            ST_MUL_PRE: dp_cmd.op = pica_pkg::OP_MUL_PRE;
            ST_MUL_P:   dp_cmd.op = pica_pkg::OP_MUL_P;
            ST_MUL_LO:  dp_cmd.op = pica_pkg::OP_MUL_LO;
            ST_MUL_HI:  dp_cmd.op = pica_pkg::OP_MUL_HI;
            ST_INC:     dp_cmd.op = pica_pkg::OP_INC;
            ST_INTEG:   dp_cmd.op = pica_pkg::OP_INTEG;
            ST_SUM:     dp_cmd.op = pica_pkg::OP_SUM;
            ST_DONE:
            begin
                if (out_free)
                begin
                    dp_cmd.op = dp_status.clear ? pica_pkg::OP_CLEAR : pica_pkg::OP_OUT;
                end
            end
            default:    dp_cmd.op = pica_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_MUL_PRE;
                    end
                end
                // A reset command needs no arithmetic and goes straight to the write.
                ST_MUL_PRE: state_reg <= dp_status.clear ? ST_DONE : ST_MUL_P;
                ST_MUL_P:   state_reg <= ST_MUL_LO;
                ST_MUL_LO:  state_reg <= ST_MUL_HI;
                ST_MUL_HI:  state_reg <= ST_INC;
                ST_INC:     state_reg <= ST_INTEG;
                ST_INTEG:   state_reg <= ST_SUM;
                ST_SUM:     state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pica_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI controller datapath
// Configuration registers, controller state, one shared multiplier and the
// saturating adders and limit compares of the clamping logic.
// ----------------------------------------------------------------------------
module pica_datapath
#(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int INTEGRATOR_WIDTH = 48
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pica_pkg::dp_cmd_t                     dp_cmd,
    output pica_pkg::dp_status_t                  dp_status,
    input  logic                                  cfg_we,
    input  logic [pica_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pica_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]        reference,
    input  logic signed [SAMPLE_WIDTH-1:0]        actual,
    input  logic                                  ext_clamp,
    output logic signed [pica_pkg::DRIVE_W-1:0]   drive,
    output logic                                  clamp_active
);

    localparam int TW    = pica_pkg::TIME_W;
    localparam int FW_Q  = pica_pkg::FRAC_W;
    localparam int SW    = pica_pkg::SUM_W;
    localparam int DW    = pica_pkg::DRIVE_W;
    localparam int EW    = SAMPLE_WIDTH + 1;                  // error
    localparam int PW    = SAMPLE_WIDTH + pica_pkg::GAIN_W + 1; // error times gain
    localparam int SPLIT = TW;                                // low part of pre
    localparam int HW    = PW - SPLIT;                        // high part of pre
    localparam int MA    = (EW > SPLIT + 1) ? EW : SPLIT + 1;
    localparam int MB    = TW + 1;
    localparam int PRW   = MA + MB;
    localparam int LOW   = SPLIT + TW;
    localparam int FW    = PW + TW;                           // full pre * sample_time
    localparam int INCW  = FW - FW_Q;
    localparam int IW    = INTEGRATOR_WIDTH;
    localparam int IAW   = ((IW > INCW) ? IW : INCW) + 1;
    localparam int PSW   = PW + pica_pkg::GAIN_FRAC;
    localparam int SSW   = ((IW > PSW) ? IW : PSW) + 1;
    localparam int WW    = (SSW > SW + 1) ? SSW : SW + 1;

    // Configuration
    logic [pica_pkg::GAIN_W-1:0]         kp_reg;
    logic [pica_pkg::GAIN_W-1:0]         ki_reg;
    logic [TW-1:0]                       st_reg;
    logic signed [pica_pkg::LIMIT_W-1:0] y_max_reg;
    logic signed [pica_pkg::LIMIT_W-1:0] y_min_reg;

    // Controller state
    logic signed [IW-1:0] integrator_reg;
    logic signed [EW-1:0] prev_error_reg;
    logic                 clamp_flag_reg;

    // Working registers
    logic signed [EW-1:0]  err_reg;
    logic                  ext_clamp_reg;
    logic                  clear_reg;
    logic signed [PRW-1:0] prod_reg;
    logic signed [PW-1:0]  pre_reg;
    logic signed [PW-1:0]  p_reg;
    logic [LOW-1:0]        lo_reg;
    logic signed [INCW-1:0] inc_reg;
    logic signed [SW-1:0]  s_reg;
    logic signed [DW-1:0]  drive_reg;
    logic                  clamp_out_reg;

    logic signed [MA-1:0]  mul_a;
    logic [TW-1:0]         mul_b;
    logic signed [PRW-1:0] mul_prod;
    logic [FW-1:0]         inc_full;
    logic signed [IAW-1:0] integ_sum;
    logic signed [IW-1:0]  integ_sat;
    logic signed [PSW-1:0] p_q16;
    logic signed [WW-1:0]  s_sum;
    logic signed [SW-1:0]  s_sat;
    logic signed [SW-1:0]  y_max_q;
    logic signed [SW-1:0]  y_min_q;
    logic                  pre_pos;
    logic                  pre_neg;
    logic                  clamp_next;
    logic signed [DW-1:0]  drive_sat;

    assign dp_status.clear = clear_reg;
    assign drive           = drive_reg;
    assign clamp_active    = clamp_out_reg;

    // Shared multiplier: signed operand times unsigned operand.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (dp_cmd.op)
            pica_pkg::OP_MUL_PRE:
            begin
                mul_a = MA'(prev_error_reg);
                mul_b = TW'(ki_reg);
            end
            pica_pkg::OP_MUL_P:
            begin
                mul_a = MA'(err_reg);
                mul_b = TW'(kp_reg);
            end
            pica_pkg::OP_MUL_LO:
            begin
                mul_a = MA'({1'b0, pre_reg[SPLIT-1:0]});
                mul_b = st_reg;
            end
            pica_pkg::OP_MUL_HI:
            begin
                mul_a = MA'($signed(pre_reg[PW-1:SPLIT]));
                mul_b = st_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * $signed({1'b0, mul_b});

    // Recombine the two partial products; the increment is the floor of the
    // product over 2^16, which the arithmetic shift gives for either sign.
    assign inc_full = {prod_reg[HW+TW-1:0], {SPLIT{1'b0}}} + FW'(lo_reg);

    assign integ_sum = IAW'(integrator_reg) + IAW'(inc_reg);

    always_comb
    begin
        if (&integ_sum[IAW-1:IW-1] || ~|integ_sum[IAW-1:IW-1])
        begin
            integ_sat = integ_sum[IW-1:0];
        end
        else if (integ_sum[IAW-1])
        begin
            integ_sat = {1'b1, {(IW-1){1'b0}}};
        end
        else
        begin
            integ_sat = {1'b0, {(IW-1){1'b1}}};
        end
    end

    assign p_q16 = {p_reg, {pica_pkg::GAIN_FRAC{1'b0}}};
    assign s_sum = WW'(integrator_reg) + WW'(p_q16);

    always_comb
    begin
        if (&s_sum[WW-1:SW-1] || ~|s_sum[WW-1:SW-1])
        begin
            s_sat = s_sum[SW-1:0];
        end
        else if (s_sum[WW-1])
        begin
            s_sat = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            s_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign y_max_q = SW'($signed({y_max_reg, {FW_Q{1'b0}}}));
    assign y_min_q = SW'($signed({y_min_reg, {FW_Q{1'b0}}}));
    assign pre_pos = !pre_reg[PW-1] && (|pre_reg);
    assign pre_neg = pre_reg[PW-1];

    // The upper limit is tested first, so it wins when the limits cross.
    always_comb
    begin
        if (s_reg > y_max_q)
        begin
            clamp_next = pre_pos;
        end
        else if (s_reg < y_min_q)
        begin
            clamp_next = pre_neg;
        end
        else
        begin
            clamp_next = 1'b0;
        end
    end

    always_comb
    begin
        if (&s_reg[SW-1:FW_Q+DW-1] || ~|s_reg[SW-1:FW_Q+DW-1])
        begin
            drive_sat = s_reg[FW_Q+DW-1:FW_Q];
        end
        else if (s_reg[SW-1])
        begin
            drive_sat = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            drive_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // Configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg         <= pica_pkg::KP_RESET;
            ki_reg         <= pica_pkg::KI_RESET;
            st_reg         <= pica_pkg::ST_RESET;
            y_max_reg      <= pica_pkg::Y_MAX_RESET;
            y_min_reg      <= pica_pkg::Y_MIN_RESET;
            integrator_reg <= '0;
            prev_error_reg <= '0;
            clamp_flag_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pica_pkg::CFG_KP:          kp_reg    <= cfg_data[pica_pkg::GAIN_W-1:0];
                    pica_pkg::CFG_KI:          ki_reg    <= cfg_data[pica_pkg::GAIN_W-1:0];
                    pica_pkg::CFG_SAMPLE_TIME: st_reg    <= cfg_data[TW-1:0];
                    pica_pkg::CFG_Y_MAX:       y_max_reg <= cfg_data[pica_pkg::LIMIT_W-1:0];
                    pica_pkg::CFG_Y_MIN:       y_min_reg <= cfg_data[pica_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end

            case (dp_cmd.op)
                pica_pkg::OP_INTEG:
                begin
                    if (!ext_clamp_reg && !clamp_flag_reg)
                    begin
                        integrator_reg <= integ_sat;
                    end
                end
                pica_pkg::OP_OUT:
                begin
                    prev_error_reg <= err_reg;
                    clamp_flag_reg <= clamp_next;
                end
                pica_pkg::OP_CLEAR:
                begin
                    integrator_reg <= '0;
                    prev_error_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            err_reg       <= EW'(reference) - EW'(actual);
            ext_clamp_reg <= ext_clamp;
            clear_reg     <= cmd;
        end

        case (dp_cmd.op)
            pica_pkg::OP_MUL_PRE:
            begin
                prod_reg <= mul_prod;
            end
            pica_pkg::OP_MUL_P:
            begin
                pre_reg  <= prod_reg[PW-1:0];
                prod_reg <= mul_prod;
            end
            pica_pkg::OP_MUL_LO:
            begin
                p_reg    <= prod_reg[PW-1:0];
                prod_reg <= mul_prod;
            end
            pica_pkg::OP_MUL_HI:
            begin
                lo_reg   <= prod_reg[LOW-1:0];
                prod_reg <= mul_prod;
            end
            pica_pkg::OP_INC:
            begin
                inc_reg <= inc_full[FW-1:FW_Q];
            end
            pica_pkg::OP_SUM:
            begin
                s_reg <= s_sat;
            end
            pica_pkg::OP_OUT:
            begin
                drive_reg     <= drive_sat;
                clamp_out_reg <= clamp_next;
            end
            pica_pkg::OP_CLEAR:
            begin
                drive_reg     <= '0;
                clamp_out_reg <= clamp_flag_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/pi_controller_clamping_antiwindup.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI controller with clamping anti-windup
// Fixed-point PI controller: integrates the previous error, outputs P + I
// and raises an internal clamp flag when the output leaves its limits.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                        Contents
//  s_*       in         s_tvalid s_tready s_tdata      one sample or reset command
//                       s_tuser
//  m_*       out        m_tvalid m_tready m_tdata      drive and clamp flag
//  cfg_*     in         cfg_we cfg_index cfg_data      register writes
//
//  Between one accepted transfer and the next, the sequencer runs a sample
//  through eight steps using the single shared multiplier and the
//  saturating adders; a reset command skips from the first step to the last.
//  Reset clears the controller state and loads the register defaults.
//  The result sits in an output register; the next transfer is accepted
//  while it waits, and the sequencer holds in its last step only when a
//  new result is ready and the previous one has still not been taken.
// ----------------------------------------------------------------------------
module pi_controller_clamping_antiwindup
#(
    parameter int SAMPLE_WIDTH     = 16,
    parameter int INTEGRATOR_WIDTH = 48,
    localparam int S_TDATA_W       = ((2 * SAMPLE_WIDTH + 1 + 7) / 8) * 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // reference, actual, ext_clamp, zero fill
    input  logic [S_TDATA_W-1:0]                s_tdata,
    // cmd
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive, clamp_active, zero fill
    output logic [pica_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [pica_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pica_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pica_pkg::dp_cmd_t    dp_cmd;
    pica_pkg::dp_status_t dp_status;

    logic signed [pica_pkg::DRIVE_W-1:0] drive;
    logic                                clamp_active;

    pica_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    pica_datapath
    #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (s_tuser),
        .reference    (s_tdata[SAMPLE_WIDTH-1:0]),
        .actual       (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .ext_clamp    (s_tdata[2*SAMPLE_WIDTH]),
        .drive        (drive),
        .clamp_active (clamp_active)
    );

    assign m_tdata = {{(pica_pkg::OUT_DATA_W-pica_pkg::DRIVE_W-1){1'b0}}, clamp_active, drive};

endmodule
`default_nettype wire

/* hw/rtl/pica_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PI controller port checker
// Concurrent assertions on the stream ports of the controller, attached to
// the top level by a bind statement.
// ----------------------------------------------------------------------------
module pica_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pica_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Only one sample is in work: a transfer closes the input, and it does not reopen straight away.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted again too soon after a transfer");

    // The input closes only because a transfer was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input closed without a transfer");

    // A new result appears exactly as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result presented while the sequencer is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or was dropped");

endmodule

bind pi_controller_clamping_antiwindup pica_checker u_pica_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
